>>> sv/itoa_pkg.sv
package itoa_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int FIELD_WIDTH = 64;
    localparam int BCD_DIGITS = 20;
    localparam int BCD_WIDTH = 4 * BCD_DIGITS;
    localparam int STEP_BITS = 8;
    localparam int INDEX_WIDTH = 5;
    localparam int CHAR_WIDTH = 7;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2D;

    typedef enum logic
    {
        OP_DEC = 1'b0,
        OP_HEX = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic                   hex;
        logic                   neg;
        logic [FIELD_WIDTH-1:0] bin;
        logic [BCD_WIDTH-1:0]   bcd;
    } itoa_stage_t;

    function automatic logic [CHAR_WIDTH-1:0] nibble_to_char(input logic [3:0] d);
        logic [CHAR_WIDTH-1:0] c;
        if (d >= 4'd10)
        begin
            c = CHAR_UPPER_A + {3'd0, d - 4'd10};
        end
        else
        begin
            c = CHAR_ZERO + {3'd0, d};
        end
        return c;
    endfunction

endpackage

>>> sv/itoa_num_if.sv
interface itoa_num_if;
    logic                                valid;
    logic                                ready;
    logic [itoa_pkg::FIELD_WIDTH-1:0]    value;
    logic                                opcode;

    modport source (output valid, output value, output opcode, input ready);
    modport sink (input valid, input value, input opcode, output ready);
endinterface

>>> sv/itoa_char_if.sv
interface itoa_char_if;
    logic                                valid;
    logic                                ready;
    logic [itoa_pkg::CHAR_WIDTH-1:0]     char_out;
    logic [itoa_pkg::INDEX_WIDTH-1:0]    char_index;
    logic                                last;

    modport source (output valid, output char_out, output char_index, output last, input ready);
    modport sink (input valid, input char_out, input char_index, input last, output ready);
endinterface

>>> sv/itoa_front.sv
module itoa_front #(
    parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    itoa_num_if.sink              number,
    output logic                  out_valid,
    input  logic                  out_ready,
    output itoa_pkg::itoa_stage_t out_data
);

    localparam int NSTAGE = (VALUE_WIDTH + itoa_pkg::STEP_BITS - 1) / itoa_pkg::STEP_BITS;
    localparam int PAD = itoa_pkg::FIELD_WIDTH - NSTAGE * itoa_pkg::STEP_BITS;
    localparam logic [itoa_pkg::FIELD_WIDTH-1:0] MASK =
        {itoa_pkg::FIELD_WIDTH{1'b1}} >> (itoa_pkg::FIELD_WIDTH - VALUE_WIDTH);

    logic                  valid_reg;
    itoa_pkg::itoa_stage_t data_reg;
    itoa_pkg::itoa_stage_t data_next;
    logic [itoa_pkg::FIELD_WIDTH-1:0] v;
    logic [itoa_pkg::FIELD_WIDTH-1:0] mag;

    assign number.ready = !valid_reg || out_ready;

    always_comb
    begin
        v = number.value & MASK;
        data_next.hex = (number.opcode == itoa_pkg::OP_HEX);
        data_next.neg = !data_next.hex && v[VALUE_WIDTH-1];
        mag = data_next.neg ? ((~v + 64'd1) & MASK) : v;
        // msb first, leading zero padding up to a whole number of stages
        data_next.bin = mag << PAD;
        data_next.bcd = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (number.ready)
        begin
            valid_reg <= number.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (number.ready && number.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

>>> sv/itoa_dabble_stage.sv
module itoa_dabble_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  itoa_pkg::itoa_stage_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output itoa_pkg::itoa_stage_t out_data
);

    logic                  valid_reg;
    itoa_pkg::itoa_stage_t data_reg;
    itoa_pkg::itoa_stage_t data_next;

    assign in_ready = !valid_reg || out_ready;

    // shift-add-3 in decimal mode, plain shift in hex mode
    always_comb
    begin
        data_next = in_data;
        for (int s = 0; s < itoa_pkg::STEP_BITS; s++)
        begin
            if (!data_next.hex)
            begin
                for (int d = 0; d < itoa_pkg::BCD_DIGITS; d++)
                begin
                    if (data_next.bcd[4*d +: 4] >= 4'd5)
                    begin
                        data_next.bcd[4*d +: 4] = data_next.bcd[4*d +: 4] + 4'd3;
                    end
                end
            end
            data_next.bcd = {data_next.bcd[itoa_pkg::BCD_WIDTH-2:0],
                             data_next.bin[itoa_pkg::FIELD_WIDTH-1]};
            data_next.bin = {data_next.bin[itoa_pkg::FIELD_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

>>> sv/itoa_emit.sv
module itoa_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  itoa_pkg::itoa_stage_t in_data,
    itoa_char_if.source           text
);

    logic                                   busy_reg;
    logic                                   sign_reg;
    logic [itoa_pkg::BCD_WIDTH-1:0]         buf_reg;
    logic [itoa_pkg::INDEX_WIDTH-1:0]       dp_reg;
    logic [itoa_pkg::INDEX_WIDTH-1:0]       idx_reg;
    logic [itoa_pkg::INDEX_WIDTH-1:0]       nd;
    logic                                   take;

    // digit count: highest non-zero digit, at least one
    always_comb
    begin
        nd = 5'd1;
        for (int d = 0; d < itoa_pkg::BCD_DIGITS; d++)
        begin
            if (in_data.bcd[4*d +: 4] != 4'd0)
            begin
                nd = itoa_pkg::INDEX_WIDTH'(d + 1);
            end
        end
    end

    assign text.valid = busy_reg;
    assign text.char_index = idx_reg;
    assign text.char_out = sign_reg ? itoa_pkg::CHAR_MINUS
                                    : itoa_pkg::nibble_to_char(buf_reg[4*dp_reg +: 4]);
    assign text.last = !sign_reg && (dp_reg == 5'd0);

    assign take = busy_reg && text.ready;
    assign in_ready = !busy_reg || (text.ready && text.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            busy_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            buf_reg <= in_data.bcd;
            sign_reg <= in_data.neg;
            dp_reg <= nd - 5'd1;
            idx_reg <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 5'd1;
            if (sign_reg)
            begin
                sign_reg <= 1'b0;
            end
            else
            begin
                dp_reg <= dp_reg - 5'd1;
            end
        end
    end

endmodule

>>> sv/integer_to_ascii_formatter.sv
// channel  direction  payload
// number   in         value[63:0], opcode (0 decimal, 1 hex)
// text     out        char_out[6:0], char_index[4:0], last
//
// an item passes a capture and negate stage, then ceil(VALUE_WIDTH/8) conversion
// stages of eight shift steps each, then the character emitter
// the emitter gives one character a cycle while text is ready, 1 to 20 per item; one item
// holds the emitter until its last character is taken, while later items wait in the stages
// reset clears every valid bit; a stall on text holds the emitter and backs up the stages
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH
) (
    input logic         clk,
    input logic         rst_n,
    itoa_num_if.sink    number,
    itoa_char_if.source text
);

    localparam int NSTAGE = (VALUE_WIDTH + itoa_pkg::STEP_BITS - 1) / itoa_pkg::STEP_BITS;

    logic                  st_valid [NSTAGE+1];
    logic                  st_ready [NSTAGE+1];
    itoa_pkg::itoa_stage_t st_data  [NSTAGE+1];

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (number),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_data  (st_data[0])
    );

    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_stage
        itoa_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_data   (st_data[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_data  (st_data[g+1])
        );
    end

    itoa_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (st_valid[NSTAGE]),
        .in_ready (st_ready[NSTAGE]),
        .in_data  (st_data[NSTAGE]),
        .text     (text)
    );

    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.char_out == itoa_pkg::CHAR_MINUS |-> text.char_index == 5'd0)
        else $error("sign not in first place");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid |-> text.char_index <= 5'd19)
        else $error("character index out of range");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.ready && !text.last
        |=> text.valid && text.char_index == $past(text.char_index) + 5'd1)
        else $error("character sequence broken");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 450;

    typedef struct packed
    {
        logic [itoa_pkg::CHAR_WIDTH-1:0]  ch;
        logic [itoa_pkg::INDEX_WIDTH-1:0] idx;
        logic                             last;
    } text_char_t;

    typedef struct
    {
        logic [63:0]       value;
        itoa_pkg::opcode_t op;
        logic              known;
        text_char_t        first_char;
    } stim_row_t;

    logic clk;
    logic rst_n;
    int   cycles;
    int   mismatches;
    int   chars_seen;
    int   numbers_sent;
    bit   stimulus_done;
    text_char_t text_expected[$];

    itoa_num_if  number();
    itoa_char_if text();

    integer_to_ascii_formatter u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number),
        .text   (text)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    function automatic void predict_text(input logic [63:0] value, input itoa_pkg::opcode_t op);
        logic [63:0] mag;
        logic [7:0]  digits[20];
        logic [63:0] radix;
        logic [63:0] d;
        int          nd;
        int          pos;
        text_char_t  c;
        mag = value;
        nd = 0;
        pos = 0;
        radix = (op == itoa_pkg::OP_HEX) ? 64'd16 : 64'd10;
        if (op == itoa_pkg::OP_DEC && value[63])
        begin
            mag = ~value + 64'd1;
            c.ch = itoa_pkg::CHAR_MINUS;
            c.idx = '0;
            c.last = 1'b0;
            text_expected.push_back(c);
            pos = 1;
        end
        do
        begin
            d = mag % radix;
            digits[nd] = (d >= 10) ? 8'(itoa_pkg::CHAR_UPPER_A) + 8'(d - 10)
                                   : 8'(itoa_pkg::CHAR_ZERO) + 8'(d);
            nd++;
            mag = mag / radix;
        end
        while (mag != 0 && nd < 19);
        for (int k = nd - 1; k >= 0; k--)
        begin
            c.ch = digits[k][6:0];
            c.idx = pos[4:0];
            c.last = (k == 0);
            text_expected.push_back(c);
            pos++;
        end
    endfunction

    // valid stays high into the next item when there is no gap
    task automatic send_number(input logic [63:0] value, input itoa_pkg::opcode_t op);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            number.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        number.valid <= 1'b1;
        number.value <= value;
        number.opcode <= op;
        do
        begin
            @(posedge clk);
        end
        while (!number.ready);
        predict_text(value, op);
        numbers_sent++;
    endtask

    task automatic drain_text();
        do
        begin
            @(posedge clk);
        end
        while (text_expected.size() != 0);
    endtask

    // receiver
    initial
    begin
        text_char_t got;
        text_char_t want;
        int stall;
        text.ready <= 1'b0;
        mismatches = 0;
        chars_seen = 0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                text.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            text.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!text.valid);
            got.ch = text.char_out;
            got.idx = text.char_index;
            got.last = text.last;
            chars_seen++;
            if (text_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected char %h idx %0d", got.ch, got.idx);
            end
            else
            begin
                want = text_expected.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("char mismatch: exp ch %h idx %0d last %b, got ch %h idx %0d last %b",
                            want.ch, want.idx, want.last, got.ch, got.idx, got.last);
                end
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t r;
        logic [63:0] v;
        int bits;
        rst_n = 1'b0;
        number.valid = 1'b0;
        number.value = '0;
        number.opcode = itoa_pkg::OP_DEC;
        numbers_sent = 0;
        stimulus_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{64'd0, itoa_pkg::OP_DEC, 1'b1, '{itoa_pkg::CHAR_ZERO, 5'd0, 1'b1}});
        rows.push_back('{64'd0, itoa_pkg::OP_HEX, 1'b1, '{itoa_pkg::CHAR_ZERO, 5'd0, 1'b1}});
        rows.push_back('{64'h8000_0000_0000_0000, itoa_pkg::OP_DEC, 1'b1,
            '{itoa_pkg::CHAR_MINUS, 5'd0, 1'b0}});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, itoa_pkg::OP_DEC, 1'b1,
            '{itoa_pkg::CHAR_MINUS, 5'd0, 1'b0}});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, itoa_pkg::OP_HEX, 1'b1,
            '{itoa_pkg::CHAR_UPPER_A + 7'd5, 5'd0, 1'b0}});
        rows.push_back('{64'd9, itoa_pkg::OP_DEC, 1'b1, '{itoa_pkg::CHAR_ZERO + 7'd9, 5'd0, 1'b1}});
        rows.push_back('{64'd10, itoa_pkg::OP_HEX, 1'b1, '{itoa_pkg::CHAR_UPPER_A, 5'd0, 1'b1}});
        rows.push_back('{64'h7FFF_FFFF_FFFF_FFFF, itoa_pkg::OP_DEC, 1'b0, '{default: '0}});
        rows.push_back('{64'h8000_0000_0000_0000, itoa_pkg::OP_HEX, 1'b0, '{default: '0}});
        rows.push_back('{64'd10, itoa_pkg::OP_DEC, 1'b0, '{default: '0}});
        rows.push_back('{64'd15, itoa_pkg::OP_HEX, 1'b0, '{default: '0}});
        rows.push_back('{64'd16, itoa_pkg::OP_HEX, 1'b0, '{default: '0}});
        rows.push_back('{64'd1234567890, itoa_pkg::OP_DEC, 1'b0, '{default: '0}});
        rows.push_back('{64'h0123_4567_89AB_CDEF, itoa_pkg::OP_HEX, 1'b0, '{default: '0}});
        rows.push_back('{-64'sd10000, itoa_pkg::OP_DEC, 1'b0, '{default: '0}});
        rows.push_back('{64'd10_000_000_000_000_000_000 - 64'd1, itoa_pkg::OP_DEC, 1'b0,
            '{default: '0}});
        rows.push_back('{64'hAAAA_AAAA_AAAA_AAAA, itoa_pkg::OP_HEX, 1'b0, '{default: '0}});
        rows.push_back('{64'h5555_5555_5555_5555, itoa_pkg::OP_DEC, 1'b0, '{default: '0}});

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.known)
            begin
                number.valid <= 1'b0;
                drain_text();
                send_number(r.value, r.op);
                if (text_expected[0] !== r.first_char)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: predicted first char %h, table says %h",
                            i, text_expected[0].ch, r.first_char.ch);
                end
            end
            else
            begin
                send_number(r.value, r.op);
            end
        end

        // pause until the text side has caught up
        number.valid <= 1'b0;
        drain_text();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            v = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: bits = 64;
                1: bits = $urandom_range(1, 16);
                default: bits = $urandom_range(1, 64);
            endcase
            if (bits < 64)
            begin
                v = v & ((64'd1 << bits) - 64'd1);
                if ($urandom_range(0, 3) == 0)
                    v = ~v;
            end
            send_number(v, itoa_pkg::opcode_t'($urandom_range(0, 1)));
        end
        number.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin
        wait (stimulus_done);
        drain_text();
        repeat (200) @(posedge clk);
        $display("sent %0d numbers in decimal and hex, checked %0d characters",
            numbers_sent, chars_seen);
        if (mismatches == 0 && text_expected.size() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("%0d mismatches, %0d characters outstanding",
                mismatches, text_expected.size());
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
